// File: src/mtep_pkg.sv
`timescale 1ns / 1ps
// mtep_pkg: shared types and constants for the midi track event parser
// no dependencies; used by midi_track_event_parser_core

package mtep_pkg;

    // status and meta type codes
    localparam logic [7:0] STATUS_SYSEX     = 8'hF0;
    localparam logic [7:0] STATUS_SYSEX_END = 8'hF7;
    localparam logic [7:0] STATUS_META      = 8'hFF;
    localparam logic [7:0] META_END_TRACK   = 8'h2F;
    localparam logic [7:0] META_TEMPO       = 8'h51;
    localparam logic [7:0] META_TIME_SIG    = 8'h58;
    localparam logic [3:0] HI_PROG_CHANGE   = 4'hC;
    localparam logic [3:0] HI_CHAN_PRESSURE = 4'hD;

    localparam int DELTA_W = 28;
    localparam int LEFT_W  = 33;

    // most negative byte count, where the down count saturates
    localparam logic [LEFT_W-1:0] LEFT_FLOOR = {1'b1, {(LEFT_W-1){1'b0}}};

    // kind of a result
    typedef enum logic [2:0] {
        KIND_CHANNEL   = 3'd0,
        KIND_TEMPO     = 3'd1,
        KIND_TIME_SIG  = 3'd2,
        KIND_END_TRACK = 3'd3,
        KIND_RS_ERROR  = 3'd4,
        KIND_OVERRUN   = 3'd5
    } event_kind_t;

    // parse phase, one-hot
    typedef enum logic [9:0] {
        PH_START  = 10'b0000000001,
        PH_DELTA  = 10'b0000000010,
        PH_STATUS = 10'b0000000100,
        PH_DATA1  = 10'b0000001000,
        PH_DATA2  = 10'b0000010000,
        PH_SYSEX  = 10'b0000100000,
        PH_MTYPE  = 10'b0001000000,
        PH_MLEN   = 10'b0010000000,
        PH_MDATA  = 10'b0100000000,
        PH_STOP   = 10'b1000000000
    } phase_t;

    // one result
    typedef struct packed {
        event_kind_t        kind;
        logic [DELTA_W-1:0] delta;
        logic [7:0]         status;
        logic [7:0]         first;
        logic [7:0]         second;
        logic [31:0]        payload;
        logic [7:0]         mlen;
        logic               mismatch;
    } result_t;

endpackage

// File: src/midi_track_event_parser_core.sv
`timescale 1ns / 1ps
// midi_track_event_parser_core: byte-wise parser for a midi track chunk body
// depends on mtep_pkg

// Takes one track byte per cycle and emits channel messages and the tempo,
// time-signature and end-of-track meta events, each with its decoded delta
// time, plus running-status error and overrun results. Parsing is a single
// state update per byte, so the sustained rate is one byte per clock; the
// input stalls only while the two-entry output buffer (output register plus
// skid register) is full. After end of track, a running-status error or a
// length overrun the block stops and drops all further bytes until reset.
// Write track_length before the first byte; a write reloads the remaining
// byte count.

module midi_track_event_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] track_length,
    // byte input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    // result output
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_kind,
    output logic [27:0] delta_ticks,
    output logic [7:0]  status_value,
    output logic [7:0]  first_data,
    output logic [7:0]  second_data,
    output logic [31:0] meta_payload,
    output logic [7:0]  meta_length,
    output logic        length_mismatch
);

    // parse state
    mtep_pkg::phase_t                 phase_reg, phase_next;
    logic [mtep_pkg::DELTA_W-1:0]     acc_reg, acc_next;
    logic [7:0]                       running_reg, running_next;
    logic [7:0]                       current_reg, current_next;
    logic [7:0]                       held_reg, held_next;
    logic [7:0]                       mtype_reg, mtype_next;
    logic [7:0]                       mrem_reg, mrem_next;
    logic [7:0]                       mcount_reg, mcount_next;
    logic [31:0]                      shift_reg, shift_next;
    logic [mtep_pkg::LEFT_W-1:0]      left_reg, left_next, left_cons;

    // output buffer
    mtep_pkg::result_t                out_reg, out_next;
    mtep_pkg::result_t                skid_reg, skid_next;
    logic                             out_valid_reg, out_valid_next;
    logic                             skid_valid_reg, skid_valid_next;

    // per-byte work
    logic                             in_fire, out_fire, cfg_fire;
    logic                             left_dec, left_le_zero;
    logic                             meta_done;
    logic [7:0]                       done_count;
    logic [31:0]                      done_pay, done_aligned;
    logic                             res_valid;
    mtep_pkg::result_t                res;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_stall  = skid_valid_reg;
    assign in_fire   = in_valid && !in_stall;
    assign out_fire  = out_valid_reg && !out_stall;

    assign left_le_zero = left_reg[mtep_pkg::LEFT_W-1] || (left_reg == '0);
    assign left_cons    = (left_dec && (left_reg != mtep_pkg::LEFT_FLOOR))
                          ? left_reg - 1'b1 : left_reg;

    // byte decode
    always_comb
    begin
        phase_next   = phase_reg;
        acc_next     = acc_reg;
        running_next = running_reg;
        current_next = current_reg;
        held_next    = held_reg;
        mtype_next   = mtype_reg;
        mrem_next    = mrem_reg;
        mcount_next  = mcount_reg;
        shift_next   = shift_reg;
        left_dec     = 1'b0;
        meta_done    = 1'b0;
        done_count   = '0;
        done_pay     = '0;
        res_valid    = 1'b0;
        res          = '0;
        if (in_fire)
        begin
            unique case (phase_reg)
                mtep_pkg::PH_START, mtep_pkg::PH_DELTA:
                begin
                    if (phase_reg == mtep_pkg::PH_START && left_le_zero)
                    begin
                        // overrun: no byte left for a new event
                        phase_next   = mtep_pkg::PH_STOP;
                        acc_next     = '0;
                        res_valid    = 1'b1;
                        res.kind     = mtep_pkg::KIND_OVERRUN;
                        res.mismatch = 1'b1;
                    end
                    else
                    begin
                        acc_next   = {acc_reg[mtep_pkg::DELTA_W-8:0], data_byte[6:0]};
                        left_dec   = 1'b1;
                        phase_next = data_byte[7] ? mtep_pkg::PH_DELTA : mtep_pkg::PH_STATUS;
                    end
                end
                mtep_pkg::PH_STATUS:
                begin
                    if (!data_byte[7])
                    begin
                        if (running_reg == '0)
                        begin
                            // data byte with no status to run on
                            phase_next = mtep_pkg::PH_STOP;
                            res_valid  = 1'b1;
                            res.kind   = mtep_pkg::KIND_RS_ERROR;
                            res.delta  = acc_reg;
                        end
                        else
                        begin
                            // running status: byte is the first data byte
                            current_next = running_reg;
                            held_next    = data_byte;
                            left_dec     = 1'b1;
                            if (running_reg[7:4] == mtep_pkg::HI_PROG_CHANGE
                                || running_reg[7:4] == mtep_pkg::HI_CHAN_PRESSURE)
                            begin
                                res_valid  = 1'b1;
                                res.kind   = mtep_pkg::KIND_CHANNEL;
                                res.delta  = acc_reg;
                                res.status = running_reg;
                                res.first  = data_byte;
                                phase_next = mtep_pkg::PH_START;
                                acc_next   = '0;
                            end
                            else
                            begin
                                phase_next = mtep_pkg::PH_DATA2;
                            end
                        end
                    end
                    else
                    begin
                        left_dec = 1'b1;
                        if (data_byte < mtep_pkg::STATUS_SYSEX)
                        begin
                            running_next = data_byte;
                            current_next = data_byte;
                            phase_next   = mtep_pkg::PH_DATA1;
                        end
                        else if (data_byte == mtep_pkg::STATUS_SYSEX)
                        begin
                            running_next = '0;
                            phase_next   = mtep_pkg::PH_SYSEX;
                        end
                        else if (data_byte == mtep_pkg::STATUS_META)
                        begin
                            running_next = '0;
                            phase_next   = mtep_pkg::PH_MTYPE;
                        end
                        else
                        begin
                            // system common, realtime or escape: no data bytes
                            running_next = '0;
                            phase_next   = mtep_pkg::PH_START;
                            acc_next     = '0;
                        end
                    end
                end
                mtep_pkg::PH_DATA1:
                begin
                    held_next = data_byte;
                    left_dec  = 1'b1;
                    if (current_reg[7:4] == mtep_pkg::HI_PROG_CHANGE
                        || current_reg[7:4] == mtep_pkg::HI_CHAN_PRESSURE)
                    begin
                        res_valid  = 1'b1;
                        res.kind   = mtep_pkg::KIND_CHANNEL;
                        res.delta  = acc_reg;
                        res.status = current_reg;
                        res.first  = data_byte;
                        phase_next = mtep_pkg::PH_START;
                        acc_next   = '0;
                    end
                    else
                    begin
                        phase_next = mtep_pkg::PH_DATA2;
                    end
                end
                mtep_pkg::PH_DATA2:
                begin
                    left_dec   = 1'b1;
                    res_valid  = 1'b1;
                    res.kind   = mtep_pkg::KIND_CHANNEL;
                    res.delta  = acc_reg;
                    res.status = current_reg;
                    res.first  = held_reg;
                    res.second = data_byte;
                    phase_next = mtep_pkg::PH_START;
                    acc_next   = '0;
                end
                mtep_pkg::PH_SYSEX:
                begin
                    left_dec = 1'b1;
                    if (data_byte == mtep_pkg::STATUS_SYSEX_END)
                    begin
                        phase_next = mtep_pkg::PH_START;
                        acc_next   = '0;
                    end
                end
                mtep_pkg::PH_MTYPE:
                begin
                    left_dec   = 1'b1;
                    mtype_next = data_byte;
                    phase_next = mtep_pkg::PH_MLEN;
                end
                mtep_pkg::PH_MLEN:
                begin
                    left_dec    = 1'b1;
                    mrem_next   = data_byte;
                    mcount_next = '0;
                    shift_next  = '0;
                    if (data_byte == '0)
                    begin
                        meta_done = 1'b1;
                    end
                    else
                    begin
                        phase_next = mtep_pkg::PH_MDATA;
                    end
                end
                mtep_pkg::PH_MDATA:
                begin
                    left_dec = 1'b1;
                    if (mcount_reg < 8'd4)
                    begin
                        shift_next = {shift_reg[23:0], data_byte};
                    end
                    mcount_next = mcount_reg + 1'b1;
                    mrem_next   = mrem_reg - 1'b1;
                    if (mrem_reg == 8'd1)
                    begin
                        meta_done  = 1'b1;
                        done_count = mcount_reg + 1'b1;
                        done_pay   = shift_next;
                    end
                end
                mtep_pkg::PH_STOP:
                begin
                    // stopped: bytes are dropped
                end
                default:
                begin
                    phase_next = mtep_pkg::PH_START;
                    acc_next   = '0;
                end
            endcase
        end

        // left-align the kept meta payload bytes
        unique case (done_count)
            8'd0:    done_aligned = '0;
            8'd1:    done_aligned = {done_pay[7:0], 24'h0};
            8'd2:    done_aligned = {done_pay[15:0], 16'h0};
            8'd3:    done_aligned = {done_pay[23:0], 8'h0};
            default: done_aligned = done_pay;
        endcase

        // meta event complete
        if (meta_done)
        begin
            phase_next  = mtep_pkg::PH_START;
            acc_next    = '0;
            res.delta   = acc_reg;
            res.status  = mtep_pkg::STATUS_META;
            res.payload = done_aligned;
            res.mlen    = done_count;
            priority if (mtype_reg == mtep_pkg::META_END_TRACK)
            begin
                res_valid    = 1'b1;
                res.kind     = mtep_pkg::KIND_END_TRACK;
                res.mismatch = (left_cons != '0);
                phase_next   = mtep_pkg::PH_STOP;
            end
            else if (mtype_reg == mtep_pkg::META_TEMPO)
            begin
                res_valid = 1'b1;
                res.kind  = mtep_pkg::KIND_TEMPO;
            end
            else if (mtype_reg == mtep_pkg::META_TIME_SIG)
            begin
                res_valid = 1'b1;
                res.kind  = mtep_pkg::KIND_TIME_SIG;
            end
            else
            begin
                res_valid = 1'b0;
            end
        end
    end

    // byte count, reloaded by a configuration write
    always_comb
    begin
        if (cfg_fire)
        begin
            left_next = {1'b0, track_length};
        end
        else
        begin
            left_next = left_cons;
        end
    end

    // output register with skid stage
    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control and parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= mtep_pkg::PH_START;
            acc_reg        <= '0;
            running_reg    <= '0;
            current_reg    <= '0;
            held_reg       <= '0;
            mtype_reg      <= '0;
            mrem_reg       <= '0;
            mcount_reg     <= '0;
            shift_reg      <= '0;
            left_reg       <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            acc_reg        <= acc_next;
            running_reg    <= running_next;
            current_reg    <= current_next;
            held_reg       <= held_next;
            mtype_reg      <= mtype_next;
            mrem_reg       <= mrem_next;
            mcount_reg     <= mcount_next;
            shift_reg      <= shift_next;
            left_reg       <= left_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // result payload registers
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid       = out_valid_reg;
    assign event_kind      = out_reg.kind;
    assign delta_ticks     = out_reg.delta;
    assign status_value    = out_reg.status;
    assign first_data      = out_reg.first;
    assign second_data     = out_reg.second;
    assign meta_payload    = out_reg.payload;
    assign meta_length     = out_reg.mlen;
    assign length_mismatch = out_reg.mismatch;

    // skid stage only fills behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result with the output register empty");

    // once stopped, no byte produces a result
    a_stop_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == mtep_pkg::PH_STOP) |-> !res_valid)
        else $error("result produced after the parser stopped");

    // a result arriving at a stalled full output lands in the skid stage
    a_skid_catch: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && out_valid_reg && out_stall) |=> skid_valid_reg)
        else $error("result lost while the output was stalled");

endmodule
